@@ src/ffsa_pkg.sv @@
// -----------------------------------------------------------------------------
// ffsa_pkg: shared definitions for the first-fit slot allocator
// Fixed field widths, command and half codes, and the sequencer state type.
// -----------------------------------------------------------------------------
package ffsa_pkg;

   // Fixed widths of the item fields.
   localparam int LINK_SET_W = 36;
   localparam int COUNT_W    = 4;
   localparam int START_W    = 4;

   // Command codes.
   localparam logic CMD_ALLOCATE = 1'b0;
   localparam logic CMD_RELEASE  = 1'b1;

   // Spectrum half codes.
   localparam logic HALF_LOWER = 1'b0;
   localparam logic HALF_UPPER = 1'b1;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GATHER,
      ST_SCAN,
      ST_UPDATE,
      ST_DONE
   } ffsa_state_type;

endpackage

@@ src/ffsa_channels.sv @@
// -----------------------------------------------------------------------------
// ffsa_channels: request and response channels of the slot allocator
// Valid/ready channels; an item moves on an edge where both are high.
// -----------------------------------------------------------------------------
interface ffsa_req_if;
   logic                             valid;
   logic                             ready;
   logic                             command;
   logic [ffsa_pkg::LINK_SET_W-1:0]  link_set;
   logic                             half_select;
   logic [ffsa_pkg::COUNT_W-1:0]     slot_count;
   logic [ffsa_pkg::START_W-1:0]     release_start;

   modport source (
      output valid, command, link_set, half_select, slot_count, release_start,
      input  ready
   );
   modport sink (
      input  valid, command, link_set, half_select, slot_count, release_start,
      output ready
   );
endinterface

interface ffsa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          found;
   logic [ffsa_pkg::START_W-1:0]  start_slot;

   modport source (
      output valid, found, start_slot,
      input  ready
   );
   modport sink (
      input  valid, found, start_slot,
      output ready
   );
endinterface

@@ src/ffsa_ram.sv @@
// -----------------------------------------------------------------------------
// ffsa_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// -----------------------------------------------------------------------------
module ffsa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 36
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/first_fit_slot_allocator.sv @@
// -----------------------------------------------------------------------------
// first_fit_slot_allocator: first-fit spectrum slot allocation over links
// An allocate makes a gather pass over the link rows, a scan of start
// slots and an update pass; one with no free window skips the update pass,
// one with an unfitting count goes straight to the result; a release makes
// only the update pass. Each pass is set by the single RAM read port that
// visits each link row once per pass.
// One item at a time; the next item is taken while a result waits.
// Reset (synchronous) clears per-row valid bits, so every slot reads free.
// -----------------------------------------------------------------------------
module first_fit_slot_allocator #(
   parameter int NODES     = 6,
   parameter int NUM_SLOTS = 16
) (
   input  logic          clock,
   input  logic          reset,
   ffsa_req_if.sink      req,
   ffsa_rsp_if.source    rsp
);

   localparam int NUM_LINKS  = NODES * NODES;
   localparam int HALF_SLOTS = NUM_SLOTS / 2;
   localparam int IDX_W      = $clog2(NUM_LINKS);
   localparam int LCNT_W     = $clog2(NUM_LINKS + 1);
   localparam int SIDX_W     = (NUM_SLOTS > 2) ? $clog2(NUM_SLOTS) : 1;
   localparam int SUM_W      = $clog2(NUM_SLOTS + 16);

   // Sequencer and datapath registers.
   ffsa_pkg::ffsa_state_type state_ff, state_in;
   logic [LCNT_W-1:0]        lnk_ff, lnk_in;
   logic                     pend_ff, pend_in;
   logic                     pend_named_ff, pend_named_in;
   logic                     pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0]         pend_link_ff, pend_link_in;
   logic [NUM_LINKS-1:0]     row_valid_ff, row_valid_in;
   logic [NUM_LINKS-1:0]     named_ff, named_in;
   logic                     cmd_ff, cmd_in;
   logic                     half_ff, half_in;
   logic [ffsa_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [NUM_SLOTS-1:0]     occ_ff, occ_in;
   logic [NUM_SLOTS-1:0]     mask_ff, mask_in;
   logic [SIDX_W-1:0]        scan_ff, scan_in;
   logic                     found_ff, found_in;
   logic [SIDX_W-1:0]        begin_ff, begin_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_found_ff, rsp_found_in;
   logic [ffsa_pkg::START_W-1:0] rsp_start_ff, rsp_start_in;

   // Combinational control.
   logic                     accept;
   logic                     issuing;
   logic                     pass_end;
   logic                     out_free;
   logic [IDX_W-1:0]         rd_addr;
   logic [NUM_SLOTS-1:0]     rd_data;
   logic [NUM_SLOTS-1:0]     row_q;
   logic                     wr_en;
   logic [NUM_SLOTS-1:0]     wr_data;
   logic [NUM_LINKS-1:0]     req_named;
   logic [SUM_W-1:0]         win_start;
   logic [ffsa_pkg::COUNT_W-1:0] win_count;
   logic [NUM_SLOTS-1:0]     win_mask;
   logic [SUM_W-1:0]         span;
   logic                     count_ok;
   logic [SUM_W-1:0]         limit;
   logic                     window_free;
   logic                     scan_last;
   logic [SUM_W-1:0]         begin_wide;

   // Window of count slots from start, clipped to the row.
   function automatic logic [NUM_SLOTS-1:0] window_bits(
      input logic [SUM_W-1:0]             start,
      input logic [ffsa_pkg::COUNT_W-1:0] count
   );
      logic [NUM_SLOTS+15:0] ones;
      ones = ((NUM_SLOTS + 16)'(1) << count) - (NUM_SLOTS + 16)'(1);
      ones = ones << start;
      return ones[NUM_SLOTS-1:0];
   endfunction

   // Named links; link bits beyond the request field are never named.
   for (genvar k = 0; k < NUM_LINKS; k++) begin : g_named
      if (k < ffsa_pkg::LINK_SET_W) begin : g_in
         assign req_named[k] = req.link_set[k];
      end else begin : g_out
         assign req_named[k] = 1'b0;
      end
   end

   // Link row storage.
   ffsa_ram #(
      .WIDTH (NUM_SLOTS),
      .DEPTH (NUM_LINKS)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (pend_link_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Shared window unit: release window at accept, scan window otherwise.
   always_comb begin
      if (state_ff == ffsa_pkg::ST_IDLE) begin
         win_start = SUM_W'(req.release_start);
         win_count = req.slot_count;
      end else begin
         win_start = SUM_W'(scan_ff);
         win_count = count_ff;
      end
      win_mask = window_bits(win_start, win_count);
   end

   // Request checks and scan bounds.
   always_comb begin
      span        = (req.half_select == ffsa_pkg::HALF_UPPER) ?
                    SUM_W'(NUM_SLOTS - HALF_SLOTS) : SUM_W'(HALF_SLOTS);
      count_ok    = (req.slot_count != '0) && (SUM_W'(req.slot_count) <= span);
      limit       = (half_ff == ffsa_pkg::HALF_UPPER) ?
                    SUM_W'(NUM_SLOTS) : SUM_W'(HALF_SLOTS);
      window_free = ((occ_ff & win_mask) == '0);
      scan_last   = (SUM_W'(scan_ff) + SUM_W'(count_ff)) >= limit;
      begin_wide  = SUM_W'(begin_ff);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ffsa_pkg::ST_IDLE: begin
            if (accept) begin
               if (req.command == ffsa_pkg::CMD_RELEASE) begin
                  state_in = ffsa_pkg::ST_UPDATE;
               end else if (count_ok) begin
                  state_in = ffsa_pkg::ST_GATHER;
               end else begin
                  state_in = ffsa_pkg::ST_DONE;
               end
            end
         end
         ffsa_pkg::ST_GATHER: begin
            if (pass_end) begin
               state_in = ffsa_pkg::ST_SCAN;
            end
         end
         ffsa_pkg::ST_SCAN: begin
            if (window_free) begin
               state_in = ffsa_pkg::ST_UPDATE;
            end else if (scan_last) begin
               state_in = ffsa_pkg::ST_DONE;
            end
         end
         ffsa_pkg::ST_UPDATE: begin
            if (pass_end) begin
               state_in = ffsa_pkg::ST_DONE;
            end
         end
         ffsa_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = ffsa_pkg::ST_IDLE;
            end
         end
         default: state_in = ffsa_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs: handshake and RAM port control.
   always_comb begin
      req.ready = (state_ff == ffsa_pkg::ST_IDLE);
      accept    = req.valid && req.ready;
      out_free  = !rsp_valid_ff || rsp.ready;
      pass_end  = (lnk_ff == LCNT_W'(NUM_LINKS));
      issuing   = ((state_ff == ffsa_pkg::ST_GATHER) ||
                   (state_ff == ffsa_pkg::ST_UPDATE)) && !pass_end;
      rd_addr   = issuing ? lnk_ff[IDX_W-1:0] : '0;
      row_q     = pend_valid_ff ? rd_data : '0;
      wr_en     = (state_ff == ffsa_pkg::ST_UPDATE) && pend_ff && pend_named_ff;
      if (cmd_ff == ffsa_pkg::CMD_RELEASE) begin
         wr_data = row_q & ~mask_ff;
      end else begin
         wr_data = row_q | mask_ff;
      end
   end

   // Datapath next values.
   always_comb begin
      lnk_in        = lnk_ff;
      pend_in       = issuing;
      pend_named_in = issuing ? named_ff[rd_addr] : 1'b0;
      pend_valid_in = issuing ? row_valid_ff[rd_addr] : 1'b0;
      pend_link_in  = rd_addr;
      row_valid_in  = row_valid_ff;
      named_in      = named_ff;
      cmd_in        = cmd_ff;
      half_in       = half_ff;
      count_in      = count_ff;
      occ_in        = occ_ff;
      mask_in       = mask_ff;
      scan_in       = scan_ff;
      found_in      = found_ff;
      begin_in      = begin_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_found_in  = rsp_found_ff;
      rsp_start_in  = rsp_start_ff;

      if (issuing) begin
         lnk_in = lnk_ff + LCNT_W'(1);
      end

      // Mark a row valid once it has been written.
      if (wr_en) begin
         row_valid_in[pend_link_ff] = 1'b1;
      end

      unique case (state_ff)
         ffsa_pkg::ST_IDLE: begin
            if (accept) begin
               lnk_in   = '0;
               named_in = req_named;
               cmd_in   = req.command;
               half_in  = req.half_select;
               count_in = req.slot_count;
               occ_in   = '0;
               mask_in  = win_mask;
               scan_in  = (req.half_select == ffsa_pkg::HALF_UPPER) ?
                          SIDX_W'(HALF_SLOTS) : '0;
               found_in = (req.command == ffsa_pkg::CMD_RELEASE);
               begin_in = '0;
            end
         end
         ffsa_pkg::ST_GATHER: begin
            // OR the occupancy of each named link as its row arrives.
            if (pend_ff && pend_named_ff) begin
               occ_in = occ_ff | row_q;
            end
            if (pass_end) begin
               lnk_in = '0;
            end
         end
         ffsa_pkg::ST_SCAN: begin
            if (window_free) begin
               found_in = 1'b1;
               begin_in = scan_ff;
               mask_in  = win_mask;
            end else if (!scan_last) begin
               scan_in = scan_ff + SIDX_W'(1);
            end
         end
         ffsa_pkg::ST_UPDATE: begin
         end
         ffsa_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               rsp_start_in = begin_wide[ffsa_pkg::START_W-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffsa_pkg::ST_IDLE;
         lnk_ff       <= '0;
         pend_ff      <= 1'b0;
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lnk_ff       <= lnk_in;
         pend_ff      <= pend_in;
         row_valid_ff <= row_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pend_named_ff <= pend_named_in;
      pend_valid_ff <= pend_valid_in;
      pend_link_ff  <= pend_link_in;
      named_ff      <= named_in;
      cmd_ff        <= cmd_in;
      half_ff       <= half_in;
      count_ff      <= count_in;
      occ_ff        <= occ_in;
      mask_ff       <= mask_in;
      scan_ff       <= scan_in;
      found_ff      <= found_in;
      begin_ff      <= begin_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_start_ff  <= rsp_start_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.found      = rsp_found_ff;
   assign rsp.start_slot = rsp_start_ff;

endmodule

@@ tb/ffsa_alloc_checker.sv @@
// -----------------------------------------------------------------------------
// ffsa_alloc_checker: result checker for the first-fit slot allocator
// Watches both channels, keeps its own copy of the per-link slot map,
// works out the grant of every accepted request and compares it, in order,
// with the responses that leave the block.
// -----------------------------------------------------------------------------
module ffsa_alloc_checker #(
   parameter int NODES     = 6,
   parameter int NUM_SLOTS = 16
) (
   input  logic      clock,
   input  logic      reset,
   ffsa_req_if       req,
   ffsa_rsp_if       rsp,
   output int        failures,
   output int        outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_LINKS  = NODES * NODES;
   localparam int HALF_SLOTS = NUM_SLOTS / 2;
   localparam int MAX_REPORTS = 10;
   localparam int LINK_SET_W = ffsa_pkg::LINK_SET_W;
   localparam int COUNT_W    = ffsa_pkg::COUNT_W;
   localparam int START_W    = ffsa_pkg::START_W;

   typedef struct packed {
      logic               found;
      logic [START_W-1:0] start_slot;
   } grant_type;

   // Occupancy per directed link, 1 = slot in use.
   logic [NUM_SLOTS-1:0] link_occupancy [NUM_LINKS];
   grant_type            pending_grants [$];
   int                   error_count;
   int                   item_count;

   // Slots covered by a window; slots past the top of the row drop out.
   function automatic logic [NUM_SLOTS-1:0] window_mask(input int first, input int count);
      logic [NUM_SLOTS-1:0] mask;
      mask = '0;
      for (int i = 0; i < count; i++) begin
         if (first + i < NUM_SLOTS) mask[first+i] = 1'b1;
      end
      return mask;
   endfunction

   function automatic bit link_selected(input logic [LINK_SET_W-1:0] links, input int l);
      return (l < LINK_SET_W) && links[l];
   endfunction

   // Applies one request to the slot map and returns the grant it yields.
   function automatic grant_type allocate_or_release(
      input logic                  cmd,
      input logic [LINK_SET_W-1:0] links,
      input logic                  half,
      input logic [COUNT_W-1:0]    count,
      input logic [START_W-1:0]    rstart
   );
      grant_type            grant;
      logic [NUM_SLOTS-1:0] busy;
      logic [NUM_SLOTS-1:0] window;
      int                   first;
      int                   last;
      grant = '0;
      busy  = '0;
      if (cmd == ffsa_pkg::CMD_RELEASE) begin
         window = window_mask(int'(rstart), int'(count));
         for (int l = 0; l < NUM_LINKS; l++) begin
            if (link_selected(links, l)) link_occupancy[l] &= ~window;
         end
         grant.found = 1'b1;
         return grant;
      end
      first = (half == ffsa_pkg::HALF_UPPER) ? HALF_SLOTS : 0;
      last  = (half == ffsa_pkg::HALF_UPPER) ? NUM_SLOTS - 1 : HALF_SLOTS - 1;
      if (count == 0 || int'(count) > last - first + 1) return grant;
      for (int l = 0; l < NUM_LINKS; l++) begin
         if (link_selected(links, l)) busy |= link_occupancy[l];
      end
      // Lowest start in the half whose whole window is free.
      for (int s = first; s + int'(count) <= last + 1; s++) begin
         window = window_mask(s, int'(count));
         if ((busy & window) == '0) begin
            for (int l = 0; l < NUM_LINKS; l++) begin
               if (link_selected(links, l)) link_occupancy[l] |= window;
            end
            grant.found      = 1'b1;
            grant.start_slot = START_W'(s);
            return grant;
         end
      end
      return grant;
   endfunction

   always @(posedge clock) begin
      grant_type want;
      grant_type seen;
      if (reset) begin
         for (int l = 0; l < NUM_LINKS; l++) link_occupancy[l] = '0;
         pending_grants.delete();
         error_count = 0;
         item_count  = 0;
      end else begin
         // Responses are matched against the oldest pending grant.
         if (rsp.valid && rsp.ready) begin
            seen.found      = rsp.found;
            seen.start_slot = rsp.start_slot;
            if (pending_grants.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("[%0t] response item with none pending: found=%0b start=%0d",
                           $realtime, seen.found, seen.start_slot);
            end else begin
               want = pending_grants.pop_front();
               item_count++;
               if (seen.found !== want.found || seen.start_slot !== want.start_slot) begin
                  error_count++;
                  if (error_count <= MAX_REPORTS)
                     $display(
                        "[%0t] item %0d: expected found=%0b start=%0d, got found=%0b start=%0d",
                        $realtime, item_count, want.found, want.start_slot,
                        seen.found, seen.start_slot);
               end
            end
         end
         if (req.valid && req.ready) begin
            pending_grants.push_back(allocate_or_release(req.command, req.link_set,
                                                         req.half_select, req.slot_count,
                                                         req.release_start));
         end
      end
      failures    <= error_count;
      outstanding <= pending_grants.size();
   end

endmodule

@@ tb/tb_top.sv @@
// -----------------------------------------------------------------------------
// tb_top: testbench for the first-fit slot allocator
// Drives directed corner cases and then a long run of path-shaped allocate
// and release requests with random idling on both channels, including one
// long response hold-off; the checker beside the block judges every result.
// -----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NODES           = 6;
   localparam int NUM_SLOTS       = 16;
   localparam int RANDOM_ITEMS    = 1300;
   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int HOLD_OFF_AT     = 8000;
   localparam int HOLD_OFF_CYCLES = 600;
   localparam int DRAIN_CYCLES    = 120;
   localparam int LINK_SET_W      = ffsa_pkg::LINK_SET_W;
   localparam int COUNT_W         = ffsa_pkg::COUNT_W;
   localparam int START_W         = ffsa_pkg::START_W;

   logic clock;
   logic reset;
   int   failures;
   int   outstanding;
   int   cycle_count;

   ffsa_req_if req_ch ();
   ffsa_rsp_if rsp_ch ();

   first_fit_slot_allocator #(
      .NODES     (NODES),
      .NUM_SLOTS (NUM_SLOTS)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   ffsa_alloc_checker #(
      .NODES     (NODES),
      .NUM_SLOTS (NUM_SLOTS)
   ) checker_i (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .failures    (failures),
      .outstanding (outstanding)
   );

   // Clock generation.
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog on the total run length.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Idle length: mostly none or short, now and then long.
   function automatic int idle_cycles();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // A route of one to three hops between distinct nodes.
   function automatic logic [LINK_SET_W-1:0] route_links();
      logic [LINK_SET_W-1:0] links;
      int                    hops;
      int                    here;
      int                    next_node;
      links = '0;
      hops  = $urandom_range(1, 3);
      here  = $urandom_range(0, NODES - 1);
      for (int h = 0; h < hops; h++) begin
         next_node = $urandom_range(0, NODES - 2);
         if (next_node >= here) next_node++;
         links[here*NODES+next_node] = 1'b1;
         here = next_node;
      end
      return links;
   endfunction

   function automatic logic [LINK_SET_W-1:0] random_links();
      return LINK_SET_W'({$urandom(), $urandom()});
   endfunction

   // Offers one request item and returns once it has been accepted.
   task automatic offer_request(input logic cmd, input logic [LINK_SET_W-1:0] links,
                                input logic half, input logic [COUNT_W-1:0] count,
                                input logic [START_W-1:0] rstart);
      int gap;
      gap = idle_cycles();
      req_ch.valid         <= 1'b1;
      req_ch.command       <= cmd;
      req_ch.link_set      <= links;
      req_ch.half_select   <= half;
      req_ch.slot_count    <= count;
      req_ch.release_start <= rstart;
      do @(posedge clock); while (!req_ch.ready);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Response side: random stalls plus one long hold-off.
   initial begin
      int stall;
      int run;
      int cycles_seen;
      bit held;
      cycles_seen = 0;
      held        = 1'b0;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (!held && cycles_seen >= HOLD_OFF_AT) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            cycles_seen += HOLD_OFF_CYCLES;
            held = 1'b1;
         end else begin
            stall = idle_cycles();
            if (stall > 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
            rsp_ch.ready <= 1'b1;
            run = $urandom_range(1, 24);
            repeat (run) @(posedge clock);
            cycles_seen += stall + run;
         end
      end
   end

   // Stimulus and verdict.
   initial begin
      logic [LINK_SET_W-1:0] recent_sets [8];
      logic [LINK_SET_W-1:0] links;
      logic [LINK_SET_W-1:0] all_links;
      logic [LINK_SET_W-1:0] top_link;
      logic                  cmd;
      logic [COUNT_W-1:0]    count;
      int                    roll;

      all_links = '1;
      top_link  = '0;
      top_link[LINK_SET_W-1] = 1'b1;
      for (int k = 0; k < 8; k++) recent_sets[k] = route_links();

      reset                <= 1'b1;
      req_ch.valid         <= 1'b0;
      req_ch.command       <= ffsa_pkg::CMD_ALLOCATE;
      req_ch.link_set      <= '0;
      req_ch.half_select   <= ffsa_pkg::HALF_LOWER;
      req_ch.slot_count    <= '0;
      req_ch.release_start <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: fill link 0 and probe around it.
      offer_request(ffsa_pkg::CMD_ALLOCATE, 36'h1, ffsa_pkg::HALF_LOWER, 4'd8, 4'd0);
      offer_request(ffsa_pkg::CMD_ALLOCATE, 36'h1, ffsa_pkg::HALF_LOWER, 4'd1, 4'd15);
      offer_request(ffsa_pkg::CMD_ALLOCATE, 36'h1, ffsa_pkg::HALF_UPPER, 4'd8, 4'd0);
      offer_request(ffsa_pkg::CMD_ALLOCATE, all_links, ffsa_pkg::HALF_UPPER, 4'd1, 4'd0);
      // Count larger than the half, zero count, and the widest count field.
      offer_request(ffsa_pkg::CMD_ALLOCATE, 36'h2, ffsa_pkg::HALF_LOWER, 4'd9, 4'd0);
      offer_request(ffsa_pkg::CMD_ALLOCATE, 36'h2, ffsa_pkg::HALF_UPPER, 4'd0, 4'd0);
      offer_request(ffsa_pkg::CMD_ALLOCATE, 36'h2, ffsa_pkg::HALF_UPPER, 4'd15, 4'd0);
      // Empty link set succeeds at the bottom of the half and marks nothing.
      offer_request(ffsa_pkg::CMD_ALLOCATE, '0, ffsa_pkg::HALF_LOWER, 4'd3, 4'd0);
      offer_request(ffsa_pkg::CMD_ALLOCATE, '0, ffsa_pkg::HALF_UPPER, 4'd8, 4'd0);
      // Zero-count release, then a release that runs past the last slot.
      offer_request(ffsa_pkg::CMD_RELEASE, 36'h1, ffsa_pkg::HALF_UPPER, 4'd0, 4'd0);
      offer_request(ffsa_pkg::CMD_RELEASE, 36'h1, ffsa_pkg::HALF_LOWER, 4'd15, 4'd12);
      offer_request(ffsa_pkg::CMD_ALLOCATE, 36'h1, ffsa_pkg::HALF_UPPER, 4'd4, 4'd15);
      offer_request(ffsa_pkg::CMD_ALLOCATE, 36'h1, ffsa_pkg::HALF_UPPER, 4'd1, 4'd0);
      // Clear everything, then fill every link in both halves.
      offer_request(ffsa_pkg::CMD_RELEASE, all_links, ffsa_pkg::HALF_UPPER, 4'd15, 4'd0);
      offer_request(ffsa_pkg::CMD_RELEASE, all_links, ffsa_pkg::HALF_LOWER, 4'd1, 4'd15);
      offer_request(ffsa_pkg::CMD_ALLOCATE, all_links, ffsa_pkg::HALF_LOWER, 4'd8, 4'd0);
      offer_request(ffsa_pkg::CMD_ALLOCATE, all_links, ffsa_pkg::HALF_UPPER, 4'd8, 4'd0);
      // Hole in the highest link: a fitting window and one too wide.
      offer_request(ffsa_pkg::CMD_RELEASE, top_link, ffsa_pkg::HALF_LOWER, 4'd2, 4'd3);
      offer_request(ffsa_pkg::CMD_ALLOCATE, top_link, ffsa_pkg::HALF_LOWER, 4'd3, 4'd0);
      offer_request(ffsa_pkg::CMD_ALLOCATE, top_link, ffsa_pkg::HALF_LOWER, 4'd2, 4'd0);
      // Free the hole again, then clear every link; the hole's slots are released twice.
      offer_request(ffsa_pkg::CMD_RELEASE, top_link, ffsa_pkg::HALF_LOWER, 4'd2, 4'd3);
      offer_request(ffsa_pkg::CMD_RELEASE, all_links, ffsa_pkg::HALF_LOWER, 4'd8, 4'd0);
      offer_request(ffsa_pkg::CMD_RELEASE, all_links, ffsa_pkg::HALF_UPPER, 4'd8, 4'd8);
      offer_request(ffsa_pkg::CMD_ALLOCATE, 36'h8_0000_0001, ffsa_pkg::HALF_UPPER,
                    4'd5, 4'd7);

      // Random: mostly route-shaped allocations contending on shared links,
      // releases that mostly hit recently used routes, and some noise.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 70)      links = route_links();
         else if (roll < 82) links = random_links();
         else if (roll < 87) links = '0;
         else if (roll < 90) links = all_links;
         else begin
            links = '0;
            links[$urandom_range(0, LINK_SET_W - 1)] = 1'b1;
         end
         count = ($urandom_range(0, 99) < 85) ? COUNT_W'($urandom_range(1, 8))
                                              : COUNT_W'($urandom_range(0, 15));
         cmd = ($urandom_range(0, 99) < 35) ? ffsa_pkg::CMD_RELEASE : ffsa_pkg::CMD_ALLOCATE;
         if (cmd == ffsa_pkg::CMD_RELEASE) begin
            if ($urandom_range(0, 99) < 65) links = recent_sets[$urandom_range(0, 7)];
         end else begin
            recent_sets[$urandom_range(0, 7)] = links;
         end
         offer_request(cmd, links, 1'($urandom()), count,
                       START_W'($urandom_range(0, 15)));
      end

      // Drain: wait for every pending grant, then a little longer.
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && outstanding == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
